FILE: rtl/core/ffba_pkg.sv
`timescale 1ns / 1ps

package ffba_pkg;

   // default heap size in block units
   localparam int NUM_UNITS_DEF = 1024;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOFIT    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_NOTALLOC = 3'd3,
      ST_ZERO     = 3'd4
   } status_type;

   // one request
   typedef struct packed {
      kind_type    kind;
      logic [10:0] block_count;
      logic [11:0] unit_index;
   } req_type;

   // one result
   typedef struct packed {
      status_type  status;
      logic [9:0]  start_unit;
   } rsp_type;

endpackage

FILE: rtl/core/first_fit_block_allocator.sv
`timescale 1ns / 1ps

// First-fit block allocator over a heap of NUM_UNITS units.
// Request channel (req_valid / req_stall / req_payload): an allocate request
// carries block_count, a free request carries unit_index. Request channel
// is stalled while a request is being worked on; one request at a time.
// Result channel (rsp_valid / rsp_stall / rsp_payload): one result per
// request, status and start_unit, held in an output register until taken.
// Run headers live in one single-port-write RAM with a registered read.
// The walk reads one run header per cycle: one per run walked, plus the
// successor header on a free; the remainder header of a split allocate
// is written in a state of its own. Zero size and out of range requests
// go straight to the result stage without a header read. The next request
// is taken at the edge after its predecessor's result enters the output
// register. Reset: synchronous, active high; the heap becomes one free run.
// Entry 0 is covered by a reset flag, so there is no clearing pass and the
// block takes a request on the first cycle after reset.
// While rsp_stall is high the finished result waits in the output register;
// the next request is taken meanwhile and waits in its result stage.

module first_fit_block_allocator
#(
   parameter int NUM_UNITS = ffba_pkg::NUM_UNITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffba_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffba_pkg::rsp_type rsp_payload
);

   import ffba_pkg::*;

   localparam int AW    = $clog2(NUM_UNITS);
   localparam int LEN_W = $clog2(NUM_UNITS + 1);
   localparam int HDR_W = LEN_W + 1;
   localparam int PNW   = LEN_W + 1;
   localparam int CW    = (LEN_W > 11) ? LEN_W : 11;
   localparam int IW    = (LEN_W + 1 > 12) ? LEN_W + 1 : 12;
   localparam int SW    = (LEN_W > 10) ? LEN_W : 10;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_A_CHK  = 6'b000010,
      S_A_REM  = 6'b000100,
      S_F_CHK  = 6'b001000,
      S_F_NEXT = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [AW-1:0]    prev_ff, prev_in;
   logic [HDR_W-1:0] prev_hdr_ff, prev_hdr_in;
   logic             have_prev_ff, have_prev_in;
   logic [LEN_W-1:0] size_ff, size_in;
   logic [10:0]      cnt_ff, cnt_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    rem_addr_ff, rem_addr_in;
   logic [HDR_W-1:0] rem_hdr_ff, rem_hdr_in;
   status_type       res_status_ff, res_status_in;
   logic [9:0]       res_start_ff, res_start_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_payload_ff, rsp_payload_in;
   logic             hdr0_init_ff, hdr0_init_in;
   logic             rd_init_ff, rd_init_in;

   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [HDR_W-1:0] ram_wdata, ram_q;

   logic [HDR_W-1:0] hdr, hdr_abs, merge_size, merge_add;
   logic [LEN_W-1:0] len;
   logic             hdr_pos;
   logic [PNW-1:0]   pos_next;
   logic [CW-1:0]    len_c, cnt_c, rem_pos;
   logic [SW-1:0]    start_wide;
   logic             idx_ok;

   ffba_ram #(
      .WIDTH (HDR_W),
      .DEPTH (NUM_UNITS)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // header just read; entry 0 reads as the whole heap until first written
   assign hdr      = rd_init_ff ? HDR_W'(NUM_UNITS) : ram_q;
   assign hdr_abs  = hdr[HDR_W-1] ? (HDR_W'(0) - hdr) : hdr;
   assign len      = hdr_abs[LEN_W-1:0];
   assign hdr_pos  = !hdr[HDR_W-1] && (hdr != '0);
   assign pos_next = PNW'(pos_ff) + PNW'(len);

   assign len_c      = CW'(len);
   assign cnt_c      = CW'(cnt_ff);
   assign rem_pos    = CW'(pos_ff) + cnt_c;
   assign start_wide = SW'(pos_ff);
   assign idx_ok     = IW'(req_payload.unit_index) < IW'(NUM_UNITS);

   // size of the freed run, with a free successor folded in
   assign merge_add  = (ram_q != '0 && !hdr[HDR_W-1]) ? hdr : '0;
   assign merge_size = (state_ff == S_F_NEXT) ? (HDR_W'(size_ff) + merge_add)
                                              : HDR_W'(len);

   // request sequencer
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      prev_in       = prev_ff;
      prev_hdr_in   = prev_hdr_ff;
      have_prev_in  = have_prev_ff;
      size_in       = size_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      rem_addr_in   = rem_addr_ff;
      rem_hdr_in    = rem_hdr_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cnt_in       = req_payload.block_count;
               idx_in       = AW'(req_payload.unit_index);
               pos_in       = '0;
               have_prev_in = 1'b0;
               res_start_in = '0;
               if (req_payload.kind == KIND_ALLOC) begin
                  if (req_payload.block_count == '0) begin
                     res_status_in = ST_ZERO;
                     state_in      = S_RESP;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = S_A_CHK;
                  end
               end else begin
                  if (!idx_ok) begin
                     res_status_in = ST_RANGE;
                     state_in      = S_RESP;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = S_F_CHK;
                  end
               end
            end
         end

         // allocate walk: one run header per cycle
         S_A_CHK: begin
            if (len == '0) begin
               res_status_in = ST_NOFIT;
               state_in      = S_RESP;
            end else if (hdr_pos && len_c >= cnt_c) begin
               ram_we        = 1'b1;
               ram_waddr     = AW'(pos_ff);
               ram_wdata     = HDR_W'(0) - HDR_W'(cnt_ff);
               res_status_in = ST_OK;
               res_start_in  = start_wide[9:0];
               rem_addr_in   = AW'(rem_pos);
               rem_hdr_in    = HDR_W'(len_c - cnt_c);
               state_in      = (len_c > cnt_c) ? S_A_REM : S_RESP;
            end else if (pos_next >= PNW'(NUM_UNITS)) begin
               res_status_in = ST_NOFIT;
               state_in      = S_RESP;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = pos_next[AW-1:0];
               pos_in    = pos_next[LEN_W-1:0];
            end
         end

         // free header for the remainder of a split run
         S_A_REM: begin
            ram_we    = 1'b1;
            ram_waddr = rem_addr_ff;
            ram_wdata = rem_hdr_ff;
            state_in  = S_RESP;
         end

         // free walk up to the requested run start
         S_F_CHK: begin
            if (pos_ff != LEN_W'(idx_ff)) begin
               if (len == '0 || pos_next > PNW'(idx_ff)) begin
                  res_status_in = ST_NOTALLOC;
                  state_in      = S_RESP;
               end else begin
                  prev_in      = AW'(pos_ff);
                  prev_hdr_in  = hdr;
                  have_prev_in = 1'b1;
                  ram_re       = 1'b1;
                  ram_raddr    = pos_next[AW-1:0];
                  pos_in       = pos_next[LEN_W-1:0];
               end
            end else if (!hdr[HDR_W-1]) begin
               res_status_in = ST_NOTALLOC;
               state_in      = S_RESP;
            end else if (pos_next < PNW'(NUM_UNITS)) begin
               size_in   = len;
               ram_re    = 1'b1;
               ram_raddr = pos_next[AW-1:0];
               state_in  = S_F_NEXT;
            end else begin
               ram_we        = 1'b1;
               res_status_in = ST_OK;
               state_in      = S_RESP;
               if (have_prev_ff && !prev_hdr_ff[HDR_W-1] && prev_hdr_ff != '0) begin
                  ram_waddr = prev_ff;
                  ram_wdata = prev_hdr_ff + merge_size;
               end else begin
                  ram_waddr = AW'(pos_ff);
                  ram_wdata = merge_size;
               end
            end
         end

         // successor header in hand: merge and write back
         S_F_NEXT: begin
            ram_we        = 1'b1;
            res_status_in = ST_OK;
            state_in      = S_RESP;
            if (have_prev_ff && !prev_hdr_ff[HDR_W-1] && prev_hdr_ff != '0) begin
               ram_waddr = prev_ff;
               ram_wdata = prev_hdr_ff + merge_size;
            end else begin
               ram_waddr = AW'(pos_ff);
               ram_wdata = merge_size;
            end
         end

         // hand the result to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_payload_in.status     = res_status_ff;
               rsp_payload_in.start_unit = res_start_ff;
               state_in                  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // entry 0 reset flag and its tag on the read data
   assign hdr0_init_in = hdr0_init_ff && !(ram_we && ram_waddr == '0);
   assign rd_init_in   = ram_re ? (ram_raddr == '0 && hdr0_init_ff) : rd_init_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         hdr0_init_ff <= 1'b1;
         rd_init_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hdr0_init_ff <= hdr0_init_in;
         rd_init_ff   <= rd_init_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      prev_ff        <= prev_in;
      prev_hdr_ff    <= prev_hdr_in;
      have_prev_ff   <= have_prev_in;
      size_ff        <= size_in;
      cnt_ff         <= cnt_in;
      idx_ff         <= idx_in;
      rem_addr_ff    <= rem_addr_in;
      rem_hdr_ff     <= rem_hdr_in;
      res_status_ff  <= res_status_in;
      res_start_ff   <= res_start_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // an accepted request always starts work
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted request did not leave idle");

   // header writes only from the walk and merge states
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_A_CHK || state_ff == S_A_REM ||
                  state_ff == S_F_CHK || state_ff == S_F_NEXT))
      else $error("header write outside walk");

   // a write to entry 0 retires its reset value
   a_init_cleared: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_waddr == '0) |=> !hdr0_init_ff)
      else $error("entry 0 reset flag still set after write");

   // a new result comes only from the result stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result appeared outside result stage");

endmodule

FILE: rtl/core/ffba_ram.sv
`timescale 1ns / 1ps

module ffba_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read (old data on a same-address collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ffba_pkg::*;

   localparam int HEAP_UNITS = NUM_UNITS_DEF;
   // slowest request walks every header, plus split and output stages
   localparam int WALK_CYCLES = HEAP_UNITS + 16;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   // shadow heap: signed run headers, positive free, negative allocated
   logic signed [11:0] heap_hdr [HEAP_UNITS];
   rsp_type awaited_rsp[$];
   int      live_starts[$];
   int      mismatch_count = 0;
   bit      idle_on = 1'b0;
   int      rsp_hold_cycles = 0;

   first_fit_block_allocator #(.NUM_UNITS(HEAP_UNITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // applies one request to the shadow heap and returns its result
   function automatic rsp_type apply_to_heap(input req_type r);
      rsp_type res;
      int pos, prev, len, h, size, nxt;
      bit have_prev;
      res.status = ST_OK;
      res.start_unit = '0;
      pos = 0;
      prev = 0;
      have_prev = 1'b0;
      if (r.kind == KIND_ALLOC) begin
         if (r.block_count == 0) begin
            res.status = ST_ZERO;
         end else begin
            res.status = ST_NOFIT;
            while (pos < HEAP_UNITS) begin
               h = heap_hdr[pos];
               len = (h < 0) ? -h : h;
               if (len == 0) break;
               if (h > 0 && len >= int'(r.block_count)) begin
                  heap_hdr[pos] = -12'(r.block_count);
                  // exact fit leaves the next header alone
                  if (len > int'(r.block_count))
                     heap_hdr[pos + r.block_count] = 12'(len - r.block_count);
                  res.status = ST_OK;
                  res.start_unit = pos[9:0];
                  break;
               end
               pos += len;
            end
         end
      end else if (int'(r.unit_index) >= HEAP_UNITS) begin
         res.status = ST_RANGE;
      end else begin
         // walk up to the run that should start at unit_index
         while (pos < HEAP_UNITS && pos < int'(r.unit_index)) begin
            h = heap_hdr[pos];
            len = (h < 0) ? -h : h;
            if (len == 0) begin
               res.status = ST_NOTALLOC;
               break;
            end
            prev = pos;
            have_prev = 1'b1;
            pos += len;
         end
         if (res.status == ST_OK) begin
            if (pos != int'(r.unit_index) || heap_hdr[pos] >= 0) begin
               res.status = ST_NOTALLOC;
            end else begin
               size = -int'(heap_hdr[pos]);
               nxt = pos + size;
               if (nxt < HEAP_UNITS && heap_hdr[nxt] > 0)
                  size += heap_hdr[nxt];
               if (have_prev && heap_hdr[prev] > 0)
                  heap_hdr[prev] = 12'(int'(heap_hdr[prev]) + size);
               else
                  heap_hdr[pos] = 12'(size);
            end
         end
      end
      return res;
   endfunction

   // offers one request, waits for acceptance, records its outcome
   task automatic offer_request(input kind_type k, input logic [10:0] count,
                                input logic [11:0] idx);
      req_type r;
      rsp_type res;
      int gap;
      r.kind = k;
      r.block_count = count;
      r.unit_index = idx;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      res = apply_to_heap(r);
      awaited_rsp.push_back(res);
      // track allocated starts so random frees can hit them
      if (res.status == ST_OK) begin
         if (k == KIND_ALLOC) begin
            live_starts.push_back(int'(res.start_unit));
         end else begin
            for (int i = 0; i < live_starts.size(); i++) begin
               if (live_starts[i] == int'(idx)) begin
                  live_starts.delete(i);
                  break;
               end
            end
         end
      end
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_results_done();
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // field extremes, all status codes, exact fits and every merge shape
   task automatic test_directed();
      offer_request(KIND_ALLOC, 11'd0,    12'd4095);
      offer_request(KIND_ALLOC, 11'd2047, 12'd0);
      offer_request(KIND_ALLOC, 11'd1025, 12'd0);
      offer_request(KIND_FREE,  11'd2047, 12'd4095);
      offer_request(KIND_FREE,  11'd0,    12'd1024);
      offer_request(KIND_FREE,  11'd0,    12'd0);
      offer_request(KIND_FREE,  11'd0,    12'd5);
      offer_request(KIND_ALLOC, 11'd1024, 12'd0);
      offer_request(KIND_ALLOC, 11'd1,    12'd0);
      offer_request(KIND_FREE,  11'd0,    12'd0);
      offer_request(KIND_ALLOC, 11'd100,  12'd0);
      offer_request(KIND_ALLOC, 11'd200,  12'd0);
      offer_request(KIND_ALLOC, 11'd50,   12'd0);
      offer_request(KIND_FREE,  11'd0,    12'd100);
      offer_request(KIND_FREE,  11'd0,    12'd100);
      offer_request(KIND_ALLOC, 11'd200,  12'd0);
      offer_request(KIND_FREE,  11'd0,    12'd300);
      offer_request(KIND_FREE,  11'd0,    12'd0);
      offer_request(KIND_FREE,  11'd0,    12'd100);
      offer_request(KIND_ALLOC, 11'd1023, 12'd0);
      offer_request(KIND_ALLOC, 11'd1,    12'd0);
      offer_request(KIND_FREE,  11'd0,    12'd1023);
      offer_request(KIND_FREE,  11'd0,    12'd0);
      offer_request(KIND_ALLOC, 11'd1024, 12'd0);
      offer_request(KIND_FREE,  11'd0,    12'd0);
   endtask

   // result side held off long enough that the request side backs up
   task automatic test_result_backpressure();
      rsp_hold_cycles = 300;
      for (int i = 0; i < 10; i++)
         offer_request(KIND_ALLOC, 11'($urandom_range(1, 16)),
                       12'($urandom_range(0, 4095)));
   endtask

   // sender goes quiet until every outstanding result is back
   task automatic test_sender_pause();
      stop_requests();
      wait_results_done();
      for (int i = 0; i < 5; i++)
         offer_request(KIND_FREE, 11'($urandom_range(0, 2047)),
                       12'(live_starts[$urandom_range(0, live_starts.size() - 1)]));
   endtask

   // mostly well-formed alloc/free churn, some malformed requests
   task automatic test_random_traffic(input int n_items, input bit with_idle);
      int pick, count, idx;
      for (int i = 0; i < n_items; i++) begin
         idle_on = with_idle && ((i % 100) < 70);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            offer_request(kind_type'($urandom_range(0, 1)),
                          11'($urandom_range(0, 2047)), 12'($urandom_range(0, 4095)));
         end else if (pick < 15 && live_starts.size() != 0) begin
            // near a live start: mostly lands inside a run
            idx = live_starts[$urandom_range(0, live_starts.size() - 1)]
                  + $urandom_range(0, 2) - 1;
            offer_request(KIND_FREE, 11'($urandom_range(0, 2047)), 12'(idx));
         end else if (pick < 55 && live_starts.size() != 0) begin
            idx = live_starts[$urandom_range(0, live_starts.size() - 1)];
            offer_request(KIND_FREE, 11'($urandom_range(0, 2047)), 12'(idx));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      count = $urandom_range(1, 32);
            else if (pick < 95) count = $urandom_range(33, 200);
            else                count = $urandom_range(201, 1024);
            offer_request(KIND_ALLOC, 11'(count), 12'($urandom_range(0, 4095)));
         end
      end
   endtask

   // result side: random stall bursts, a long counted hold-off, or no stall
   initial begin : rsp_side
      int seg_left;
      bit seg_stall;
      seg_left = 0;
      seg_stall = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles--;
         end else if (!idle_on) begin
            rsp_stall <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_stall = ($urandom_range(0, 2) == 0);
               seg_left = seg_stall ? $urandom_range(1, 5) : $urandom_range(1, 12);
            end
            seg_left--;
            rsp_stall <= seg_stall;
         end
      end
   end

   // compare each taken result with the oldest outstanding prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result status %0d start_unit %0d", $time,
                     rsp_payload.status, rsp_payload.start_unit);
            mismatch_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_payload.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.start_unit !== want.start_unit) begin
               $display("%0t: start_unit expected %0d actual %0d", $time,
                        want.start_unit, rsp_payload.start_unit);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      for (int i = 0; i < HEAP_UNITS; i++) heap_hdr[i] = '0;
      heap_hdr[0] = 12'(HEAP_UNITS);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      idle_on = 1'b1;
      test_result_backpressure();
      test_sender_pause();
      test_random_traffic(440, 1'b1);
      test_random_traffic(100, 1'b0);

      stop_requests();
      wait_results_done();
      repeat (WALK_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("first_fit_block_allocator: match");
      else
         $display("first_fit_block_allocator: mismatch");
      $finish;
   end

   // watchdog
   initial begin
      #(64'd40_000_000);
      $display("first_fit_block_allocator: mismatch");
      $finish;
   end

endmodule
